/* design/itcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_pkg
// Types, register indexes and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package itcf_pkg;

    localparam int REG_IDX_W = 3;
    localparam int PROD_W    = 51;
    localparam int WIDE_W    = 52;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OFFSET_X  = 3'd0,
        REG_OFFSET_Y  = 3'd1,
        REG_OFFSET_Z  = 3'd2,
        REG_OFFSET_EN = 3'd3,
        REG_TILT_SCL  = 3'd4,
        REG_YAW_SCL   = 3'd5,
        REG_BLEND_W   = 3'd6,
        REG_UNUSED    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_P,
        ST_SQ_Q,
        ST_SQ_SUM,
        ST_SQRT,
        ST_CINIT,
        ST_CORDIC,
        ST_ROUND,
        ST_G_MUL,
        ST_G_ADD,
        ST_B_MUL_W,
        ST_B_MUL_V,
        ST_B_DONE,
        ST_OUT
    } t_state;

    // atan(2^-i) in degrees, Q32
    function automatic logic [39:0] atan_q32(input logic [4:0] i);
        logic [39:0] r;
        case (i)
            5'd0:  r = 40'd193273528320;
            5'd1:  r = 40'd114096026022;
            5'd2:  r = 40'd60285206653;
            5'd3:  r = 40'd30601712202;
            5'd4:  r = 40'd15360239180;
            5'd5:  r = 40'd7687607525;
            5'd6:  r = 40'd3844741810;
            5'd7:  r = 40'd1922488225;
            5'd8:  r = 40'd961258780;
            5'd9:  r = 40'd480631223;
            5'd10: r = 40'd240315841;
            5'd11: r = 40'd120157949;
            5'd12: r = 40'd60078978;
            5'd13: r = 40'd30039489;
            5'd14: r = 40'd15019744;
            5'd15: r = 40'd7509872;
            5'd16: r = 40'd3754936;
            5'd17: r = 40'd1877468;
            5'd18: r = 40'd938734;
            5'd19: r = 40'd469367;
            5'd20: r = 40'd234683;
            5'd21: r = 40'd117341;
            5'd22: r = 40'd58670;
            5'd23: r = 40'd29335;
            5'd24: r = 40'd14667;
            5'd25: r = 40'd7333;
            5'd26: r = 40'd3666;
            5'd27: r = 40'd1833;
            5'd28: r = 40'd916;
            5'd29: r = 40'd458;
            5'd30: r = 40'd229;
            5'd31: r = 40'd114;
            default: r = 40'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > WIDE_W'(64'sd2147483647)) begin
            r = 32'sh7fffffff;
        end else if (v < -WIDE_W'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/itcf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_in_if
// Input channel: one raw accelerometer and gyro triple per word.
// ----------------------------------------------------------------------------
interface itcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

/* design/itcf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_out_if
// Output channel: blended tilt angles and yaw angle per word.
// ----------------------------------------------------------------------------
interface itcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tilt_first_angle;
    logic signed [31:0] tilt_second_angle;
    logic signed [31:0] yaw_angle_out;

    modport source (output valid, tilt_first_angle, tilt_second_angle, yaw_angle_out,
                    input ready);
    modport sink   (input valid, tilt_first_angle, tilt_second_angle, yaw_angle_out,
                    output ready);
endinterface

/* design/itcf_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface itcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/imu_tilt_complementary_filter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top
// Complementary tilt filter: CORDIC accel angles, gyro integration, blending.
// ----------------------------------------------------------------------------
// channel   dir  word
// i_in      in   accel_x/y/z, gyro_x/y/z, 16 bit signed
// o_out     out  tilt_first_angle, tilt_second_angle, yaw_angle_out, 32 bit
// i_cfg     in   3 bit register index, 32 bit data, always ready
//
// one word runs the one-bit-a-cycle square root and the shared CORDIC stage
// once per tilt angle; one shared multiplier does squares, rates and blends.
// i_in is ready only when idle; a finished result waits in the output
// register and the next word may be accepted meanwhile.
// synchronous active-low reset clears control state and accumulators, config to defaults.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_top
    import itcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itcf_in_if.sink    i_in,
    itcf_out_if.source o_out,
    itcf_cfg_if.sink   i_cfg
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam int XW = 36;
    localparam int ZW = 42;

    // configuration
    logic signed [15:0] r_off_x, r_off_y, r_off_z;
    logic               r_off_en;
    logic [31:0]        r_tilt_scl, r_yaw_scl;
    logic [15:0]        r_blend_w;

    // sequencer
    t_state r_state, n_state;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic               r_pass, n_pass;
    logic [1:0]         r_axis, n_axis;
    logic               r_bsel, n_bsel;
    logic [4:0]         r_cnt, n_cnt;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PROD_W-1:0] r_hold, n_hold;
    logic [63:0]        r_v, n_v;
    logic [63:0]        r_root, n_root;
    logic signed [XW-1:0] r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic signed [31:0] r_ang1, n_ang1, r_ang2, n_ang2;
    logic signed [31:0] r_a1, n_a1, r_a2, n_a2;
    logic signed [31:0] r_acc1, n_acc1, r_acc2, n_acc2, r_yaw, n_yaw;
    logic               r_ov, n_ov;
    logic signed [31:0] r_o1, n_o1, r_o2, n_o2, r_o3, n_o3;

    // shared multiplier
    logic signed [32:0] m_a;
    logic signed [17:0] m_b;
    logic signed [PROD_W-1:0] m_p;

    logic signed [16:0] num_s, p_s, q_s, rate_s;
    logic [32:0]        sum_c;
    logic [63:0]        bit_c, trial_c;
    logic signed [XW-1:0] xs_c, ys_c;
    logic signed [ZW-1:0] at_c, zr_c;
    logic signed [WIDE_W-1:0] delta_c, bl_c;
    logic signed [31:0] ang_sel, a_sel;

    assign m_p = PROD_W'(m_a * m_b);

    always_comb begin
        if (!r_pass) begin
            num_s = -{r_ax[15], r_ax};
            p_s   = {r_ay[15], r_ay};
        end else begin
            num_s = {r_ay[15], r_ay};
            p_s   = {r_ax[15], r_ax};
        end
        q_s = {r_az[15], r_az};
        case (r_axis)
            2'd0:    rate_s = {r_gx[15], r_gx} - (r_off_en ? {r_off_x[15], r_off_x} : 17'sd0);
            2'd1:    rate_s = {r_gy[15], r_gy} - (r_off_en ? {r_off_y[15], r_off_y} : 17'sd0);
            default: rate_s = {r_gz[15], r_gz} - (r_off_en ? {r_off_z[15], r_off_z} : 17'sd0);
        endcase
        a_sel   = r_bsel ? r_a2 : r_a1;
        ang_sel = r_bsel ? r_ang2 : r_ang1;
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_SQ_P: begin
                m_a = 33'(p_s);
                m_b = 18'(p_s);
            end
            ST_SQ_Q: begin
                m_a = 33'(q_s);
                m_b = 18'(q_s);
            end
            ST_G_MUL: begin
                m_a = {1'b0, (r_axis == 2'd2) ? r_yaw_scl : r_tilt_scl};
                m_b = 18'(rate_s);
            end
            ST_B_MUL_W: begin
                m_a = 33'(a_sel);
                m_b = {2'b00, r_blend_w};
            end
            ST_B_MUL_V: begin
                m_a = 33'(ang_sel);
                m_b = 18'sd65536 - {2'b00, r_blend_w};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign sum_c   = {1'b0, r_hold[31:0]} + {1'b0, r_prod[31:0]};
    assign bit_c   = 64'd1 << {r_cnt, 1'b0};
    assign trial_c = r_root + bit_c;
    assign xs_c    = r_x >>> r_cnt;
    assign ys_c    = r_y >>> r_cnt;
    assign at_c    = ZW'({2'b00, atan_q32(r_cnt)});
    assign zr_c    = (r_z + (ZW'(1) <<< (SH - 1))) >>> SH;
    assign delta_c = (WIDE_W'(r_prod) + (WIDE_W'(1) <<< (SH - 1))) >>> SH;
    assign bl_c    = (WIDE_W'(r_hold) + WIDE_W'(r_prod) + WIDE_W'(32768)) >>> 16;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.tilt_first_angle  = r_o1;
    assign o_out.tilt_second_angle = r_o2;
    assign o_out.yaw_angle_out     = r_o3;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_axis  = r_axis;
        n_bsel  = r_bsel;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_hold  = r_hold;
        n_v     = r_v;
        n_root  = r_root;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_ang1  = r_ang1;
        n_ang2  = r_ang2;
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_acc1  = r_acc1;
        n_acc2  = r_acc2;
        n_yaw   = r_yaw;
        n_o1    = r_o1;
        n_o2    = r_o2;
        n_o3    = r_o3;
        n_ov    = (o_out.valid && o_out.ready) ? 1'b0 : r_ov;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_pass  = 1'b0;
                    n_state = ST_SQ_P;
                end
            end
            ST_SQ_P: begin
                n_prod  = m_p;
                n_state = ST_SQ_Q;
            end
            ST_SQ_Q: begin
                n_prod  = m_p;
                n_hold  = r_prod;
                n_state = ST_SQ_SUM;
            end
            ST_SQ_SUM: begin
                if (sum_c == '0) begin
                    // no denominator: angle is zero
                    if (!r_pass) begin
                        n_ang1 = '0;
                    end else begin
                        n_ang2 = '0;
                    end
                    n_state = ST_ROUND;
                    n_z     = '0;
                end else begin
                    n_v     = {sum_c[31:0], 32'd0};
                    n_root  = '0;
                    n_cnt   = 5'd31;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_v >= trial_c) begin
                    n_v    = r_v - trial_c;
                    n_root = (r_root >> 1) + bit_c;
                end else begin
                    n_root = r_root >> 1;
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = ST_CINIT;
                end
            end
            ST_CINIT: begin
                n_x     = XW'(r_root);
                n_y     = XW'(num_s) <<< 16;
                n_z     = '0;
                n_cnt   = '0;
                n_state = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (r_y >= 0) begin
                    n_x = r_x + ys_c;
                    n_y = r_y - xs_c;
                    n_z = r_z + at_c;
                end else begin
                    n_x = r_x - ys_c;
                    n_y = r_y + xs_c;
                    n_z = r_z - at_c;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // zero-denominator path arrives with z cleared, rounds to zero
                if (!r_pass) begin
                    n_ang1  = zr_c[31:0];
                    n_pass  = 1'b1;
                    n_state = ST_SQ_P;
                end else begin
                    n_ang2  = zr_c[31:0];
                    n_axis  = 2'd0;
                    n_state = ST_G_MUL;
                end
            end
            ST_G_MUL: begin
                n_prod  = m_p;
                n_state = ST_G_ADD;
            end
            ST_G_ADD: begin
                case (r_axis)
                    2'd0:    n_a1  = sat32(WIDE_W'(r_acc1) + delta_c);
                    2'd1:    n_a2  = sat32(WIDE_W'(r_acc2) - delta_c);
                    default: n_yaw = sat32(WIDE_W'(r_yaw) + delta_c);
                endcase
                if (r_axis == 2'd2) begin
                    n_bsel  = 1'b0;
                    n_state = ST_B_MUL_W;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_G_MUL;
                end
            end
            ST_B_MUL_W: begin
                n_prod  = m_p;
                n_state = ST_B_MUL_V;
            end
            ST_B_MUL_V: begin
                n_prod  = m_p;
                n_hold  = r_prod;
                n_state = ST_B_DONE;
            end
            ST_B_DONE: begin
                if (!r_bsel) begin
                    n_acc1  = sat32(bl_c);
                    n_bsel  = 1'b1;
                    n_state = ST_B_MUL_W;
                end else begin
                    n_acc2  = sat32(bl_c);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_o1    = r_acc1;
                    n_o2    = r_acc2;
                    n_o3    = r_yaw;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_acc1  <= '0;
            r_acc2  <= '0;
            r_yaw   <= '0;
            r_pass  <= 1'b0;
            r_axis  <= '0;
            r_bsel  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_acc1  <= n_acc1;
            r_acc2  <= n_acc2;
            r_yaw   <= n_yaw;
            r_pass  <= n_pass;
            r_axis  <= n_axis;
            r_bsel  <= n_bsel;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_hold <= n_hold;
        r_v    <= n_v;
        r_root <= n_root;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_ang1 <= n_ang1;
        r_ang2 <= n_ang2;
        r_a1   <= n_a1;
        r_a2   <= n_a2;
        r_o1   <= n_o1;
        r_o2   <= n_o2;
        r_o3   <= n_o3;
        if (i_in.valid && i_in.ready) begin
            r_ax <= i_in.accel_x;
            r_ay <= i_in.accel_y;
            r_az <= i_in.accel_z;
            r_gx <= i_in.gyro_x;
            r_gy <= i_in.gyro_y;
            r_gz <= i_in.gyro_z;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_off_z    <= '0;
            r_off_en   <= 1'b0;
            r_tilt_scl <= 32'd32786;
            r_yaw_scl  <= 32'd98358;
            r_blend_w  <= 16'd62915;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_OFFSET_X:  r_off_x    <= i_cfg.data[15:0];
                REG_OFFSET_Y:  r_off_y    <= i_cfg.data[15:0];
                REG_OFFSET_Z:  r_off_z    <= i_cfg.data[15:0];
                REG_OFFSET_EN: r_off_en   <= i_cfg.data[0];
                REG_TILT_SCL:  r_tilt_scl <= i_cfg.data;
                REG_YAW_SCL:   r_yaw_scl  <= i_cfg.data;
                REG_BLEND_W:   r_blend_w  <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

endmodule

/* bench/imu_tilt_complementary_filter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top_tb
// Self-checking bench for the complementary tilt filter. A driver feeds
// accelerometer and gyro words from a queue. A bit-accurate predictor
// (CORDIC tilt angles, gyro integration, blend, saturation) works out each
// expected word. A monitor compares every output word field by field.
// The run steps through several register settings, random stalls on both
// sides and a long output hold-off.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_top_tb;
    import itcf_pkg::*;

    localparam longint RAD_DEG  = 64'sd246083499207;
    localparam int     SETTLE   = 200;
    localparam int     WD_LIMIT = 6000;
    localparam int     LONG_HOLD = 700;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } t_imu_word;

    typedef struct {
        logic signed [31:0] first, second, yaw;
    } t_angle_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    itcf_in_if  in_ch ();
    itcf_out_if out_ch ();
    itcf_cfg_if cfg_ch ();

    imu_tilt_complementary_filter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and accumulators
    logic signed [15:0] m_off_x, m_off_y, m_off_z;
    logic               m_off_en;
    logic [31:0]        m_tilt_scl, m_yaw_scl;
    logic [15:0]        m_blend_w;
    logic signed [31:0] m_first_acc, m_second_acc, m_yaw_acc;

    t_imu_word   imu_pending[$];
    t_angle_word angles_expected[$];
    t_imu_word   cur_word;

    int  errors = 0;
    bit  quiet = 0;
    int  long_hold_req = 0;
    int  long_hold_done = 0;
    int  in_gap = 0;
    int  out_stall = 0;
    int  wd_cnt = 0;

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_deg(input int i);
        longint r;
        case (i)
            0: r = 64'sd193273528320;
            1: r = 64'sd114096026022;
            2: r = 64'sd60285206653;
            3: r = 64'sd30601712202;
            4: r = 64'sd15360239180;
            5: r = 64'sd7687607525;
            6: r = 64'sd3844741810;
            7: r = 64'sd1922488225;
            8: r = 64'sd961258780;
            9: r = 64'sd480631223;
            10: r = 64'sd240315841;
            default: begin
                r = RAD_DEG >>> i;
                if (3 * i < 40) r = r - (RAD_DEG >>> (3 * i)) / 3;
            end
        endcase
        return r;
    endfunction

    // atan(num / sqrt(p^2 + q^2)) in Q16.16 degrees, zero denominator gives 0
    function automatic longint tilt_angle(input longint num, input longint p, input longint q);
        longint unsigned sum;
        longint x, y, z, xs, ys;
        sum = longint'(p * p) + longint'(q * q);
        if (sum == 0) return 0;
        x = longint'(isqrt(sum << 32));
        y = num * 65536;
        z = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg(i);
            end
        end
        return (z + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint rate_delta(input logic signed [15:0] raw,
                                          input logic signed [15:0] off,
                                          input logic [31:0] scl);
        longint rate;
        rate = longint'(raw);
        if (m_off_en) rate = rate - longint'(off);
        return (rate * longint'({32'd0, scl}) + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] blend(input longint a, input longint ang);
        longint w;
        w = longint'({48'd0, m_blend_w});
        return clamp32((a * w + ang * (65536 - w) + 64'sd32768) >>> 16);
    endfunction

    function automatic t_angle_word predict_angles(input t_imu_word d);
        t_angle_word r;
        longint ang1, ang2, dx, dy, dz;
        logic signed [31:0] a1, a2;
        ang1 = tilt_angle(-longint'(d.ax), longint'(d.ay), longint'(d.az));
        ang2 = tilt_angle(longint'(d.ay), longint'(d.ax), longint'(d.az));
        dx = rate_delta(d.gx, m_off_x, m_tilt_scl);
        dy = rate_delta(d.gy, m_off_y, m_tilt_scl);
        dz = rate_delta(d.gz, m_off_z, m_yaw_scl);
        a1 = clamp32(longint'(m_first_acc) + dx);
        a2 = clamp32(longint'(m_second_acc) - dy);
        m_first_acc  = blend(a1, ang1);
        m_second_acc = blend(a2, ang2);
        m_yaw_acc    = clamp32(longint'(m_yaw_acc) + dz);
        r.first  = m_first_acc;
        r.second = m_second_acc;
        r.yaw    = m_yaw_acc;
        return r;
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [31:0] data);
        case (idx)
            REG_OFFSET_X:  m_off_x = data[15:0];
            REG_OFFSET_Y:  m_off_y = data[15:0];
            REG_OFFSET_Z:  m_off_z = data[15:0];
            REG_OFFSET_EN: m_off_en = data[0];
            REG_TILT_SCL:  m_tilt_scl = data;
            REG_YAW_SCL:   m_yaw_scl = data;
            REG_BLEND_W:   m_blend_w = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_word rand_word();
        t_imu_word d;
        d.ax = rand_sample();
        d.ay = rand_sample();
        d.az = rand_sample();
        d.gx = rand_sample();
        d.gy = rand_sample();
        d.gz = rand_sample();
        return d;
    endfunction

    function automatic t_imu_word mk_word(input int ax, ay, az, gx, gy, gz);
        t_imu_word d;
        d.ax = 16'(ax);
        d.ay = 16'(ay);
        d.az = 16'(az);
        d.gx = 16'(gx);
        d.gy = 16'(gy);
        d.gz = 16'(gz);
        return d;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                angles_expected.push_back(predict_angles(cur_word));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (imu_pending.size() > 0) begin
                    cur_word = imu_pending.pop_front();
                    in_ch.accel_x <= cur_word.ax;
                    in_ch.accel_y <= cur_word.ay;
                    in_ch.accel_z <= cur_word.az;
                    in_ch.gyro_x  <= cur_word.gx;
                    in_ch.gyro_y  <= cur_word.gy;
                    in_ch.gyro_z  <= cur_word.gz;
                    in_ch.valid   <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angle_word e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (angles_expected.size() == 0) begin
                    $display("%0t: unexpected word first=%0d second=%0d yaw=%0d", $time,
                             out_ch.tilt_first_angle, out_ch.tilt_second_angle,
                             out_ch.yaw_angle_out);
                    errors++;
                end else begin
                    e = angles_expected.pop_front();
                    if (out_ch.tilt_first_angle !== e.first) begin
                        $display("%0t: tilt_first_angle expected %0d actual %0d", $time,
                                 e.first, out_ch.tilt_first_angle);
                        errors++;
                    end
                    if (out_ch.tilt_second_angle !== e.second) begin
                        $display("%0t: tilt_second_angle expected %0d actual %0d", $time,
                                 e.second, out_ch.tilt_second_angle);
                        errors++;
                    end
                    if (out_ch.yaw_angle_out !== e.yaw) begin
                        $display("%0t: yaw_angle_out expected %0d actual %0d", $time,
                                 e.yaw, out_ch.yaw_angle_out);
                        errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                out_ch.ready <= 1'b0;
            end else if (long_hold_done < long_hold_req) begin
                long_hold_done++;
                out_stall = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            wd_cnt = 0;
        end else begin
            wd_cnt = wd_cnt + 1;
            if (wd_cnt >= WD_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        @(posedge i_clk);
        while (imu_pending.size() > 0 || in_ch.valid || angles_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic rand_regs();
        reg_write(REG_OFFSET_X, $urandom);
        reg_write(REG_OFFSET_Y, $urandom);
        reg_write(REG_OFFSET_Z, $urandom);
        reg_write(REG_OFFSET_EN, $urandom);
        reg_write(REG_TILT_SCL, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400000));
        reg_write(REG_YAW_SCL, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400000));
        reg_write(REG_BLEND_W, $urandom);
    endtask

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) imu_pending.push_back(rand_word());
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        in_ch.gyro_x = '0;
        in_ch.gyro_y = '0;
        in_ch.gyro_z = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        m_off_x = 0;
        m_off_y = 0;
        m_off_z = 0;
        m_off_en = 1'b0;
        m_tilt_scl = 32'd32786;
        m_yaw_scl = 32'd98358;
        m_blend_w = 16'd62915;
        m_first_acc = 0;
        m_second_acc = 0;
        m_yaw_acc = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset defaults: zero denominators, extremes, sign cases
        imu_pending.push_back(mk_word(0, 0, 0, 0, 0, 0));
        imu_pending.push_back(mk_word(1000, 0, 0, 100, -100, 50));
        imu_pending.push_back(mk_word(0, 2000, 0, 0, 0, 0));
        imu_pending.push_back(mk_word(-32768, 0, 0, 0, 0, 0));
        imu_pending.push_back(mk_word(32767, 32767, 32767, 32767, 32767, 32767));
        imu_pending.push_back(mk_word(-32768, -32768, -32768, -32768, -32768, -32768));
        imu_pending.push_back(mk_word(0, 0, 16384, -131, 131, 0));
        imu_pending.push_back(mk_word(-32768, 32767, -1, 1, -1, 1));
        imu_pending.push_back(mk_word(1, -1, 0, 0, 0, 0));
        imu_pending.push_back(mk_word(0, -32768, -32768, 0, 0, 0));
        wait_idle();

        // saturation: largest scales, largest gyro weight, biases applied
        reg_write(REG_OFFSET_X, 32'hffff_8000);
        reg_write(REG_OFFSET_Y, 32'h0000_7fff);
        reg_write(REG_OFFSET_Z, 32'h1234_8000);
        reg_write(REG_OFFSET_EN, 32'hffff_ffff);
        reg_write(REG_TILT_SCL, 32'hffff_ffff);
        reg_write(REG_YAW_SCL, 32'hffff_ffff);
        reg_write(REG_BLEND_W, 32'h0001_ffff);
        reg_write(REG_UNUSED, 32'hdead_beef);
        for (int k = 0; k < 5; k++)
            imu_pending.push_back(mk_word(0, 0, 0, 32767, -32768, 32767));
        for (int k = 0; k < 5; k++)
            imu_pending.push_back(mk_word(100, -100, 50, -32768, 32767, -32768));
        wait_idle();

        // accel angle only, no gyro scale
        reg_write(REG_BLEND_W, 32'h0);
        reg_write(REG_TILT_SCL, 32'h0);
        reg_write(REG_YAW_SCL, 32'h0);
        reg_write(REG_OFFSET_EN, 32'h0);
        queue_random(40);
        wait_idle();

        // output held off long enough for the input to stall
        rand_regs();
        long_hold_req = long_hold_req + 1;
        queue_random(200);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            rand_regs();
            queue_random(200);
            wait_idle();
        end

        // closing stretch without idling
        quiet = 1;
        reg_write(REG_OFFSET_EN, 32'h1);
        reg_write(REG_BLEND_W, 32'd62915);
        queue_random(150);
        wait_idle();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* imu_tilt_complementary_filter_top.f */
design/itcf_pkg.sv
design/itcf_in_if.sv
design/itcf_out_if.sv
design/itcf_cfg_if.sv
design/imu_tilt_complementary_filter_top.sv
bench/imu_tilt_complementary_filter_top_tb.sv
